// File: design/noc_injection_credit_interface_macros.svh
// Assertion macros for the noc injection credit interface.
`ifndef NOC_INJECTION_CREDIT_INTERFACE_MACROS_SVH
`define NOC_INJECTION_CREDIT_INTERFACE_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define NCIF_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Implication checked on the same edge.
`define NCIF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: design/ncif_pkg.sv
// Package: sizes, codes and payload types of the noc injection credit interface.
`timescale 1ns / 1ps

package ncif_pkg;

	localparam int NUM_VCS         = 4;
	localparam int VC_BUFFER_DEPTH = 8;
	localparam int QUEUE_DEPTH     = 16;
	localparam int NUM_NODES       = 64;

	localparam int VC_W   = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CRED_W = $clog2(VC_BUFFER_DEPTH + 1);
	localparam int NODE_L = $clog2(NUM_NODES + 1) - 1;
	localparam int SUM_W  = ((CNT_W > 5) ? CNT_W : 5) + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [1:0] CMD_GEN    = 2'd0;
	localparam logic [1:0] CMD_SEND   = 2'd1;
	localparam logic [1:0] CMD_CREDIT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_ID      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRAFFIC_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLITS_PER_PKT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT  = 2'd3;

	localparam logic [1:0] MODE_DIRECT     = 2'd0;
	localparam logic [1:0] MODE_TRANSPOSE  = 2'd1;
	localparam logic [1:0] MODE_COMPLEMENT = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [5:0] dest_in;
		logic [1:0] credit_vc;
		logic       channel_free;
	} in_t;

	typedef struct packed {
		logic       flit_sent;
		logic [1:0] flit_vc;
		logic       flit_head;
		logic       flit_tail;
		logic [5:0] flit_dest;
		logic       packet_dropped;
		logic [4:0] queue_fill;
	} out_t;

	typedef struct packed {
		logic [VC_W-1:0] vc;
		logic            head;
		logic            tail;
		logic [5:0]      dest;
	} flit_t;

endpackage

// File: design/noc_injection_credit_interface.sv
// Top level: noc injection interface with flit queue memory and per-VC credit memory.
//
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall   ncif_pkg::in_t
// out      from block out_valid / out_stall ncif_pkg::out_t
// cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Generate: the credit memory is scanned one entry per cycle, then the flit memory takes
//   one flit write per cycle.
// Send: flit read, credit read, update, result; straight to the result when the queue is
//   empty or the channel is busy. Credit return: update, then result. Others: result only.
// Drop or empty packet: result only. No clearing pass after reset; credit entries carry
//   valid bits and read as the buffer depth until written.
// A result waits in the output register; the next request is taken meanwhile, and
//   its result holds in the final state until that register frees.
`timescale 1ns / 1ps
`include "noc_injection_credit_interface_macros.svh"

module noc_injection_credit_interface (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ncif_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ncif_pkg::out_t                      out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ncif_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ncif_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int L_RS = ncif_pkg::NODE_L - ncif_pkg::NODE_L / 2;
	localparam int L_LS = ncif_pkg::NODE_L / 2;
	localparam logic [31:0] LOW_MASK  = 32'((64'd1 << ncif_pkg::NODE_L) - 64'd1);
	localparam logic [31:0] NODE_MASK = 32'(ncif_pkg::NUM_NODES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_SEND_RD,
		ST_SEND_CHK,
		ST_CRED,
		ST_FIN
	} state_t;

	function automatic logic [5:0] pattern_dest(logic [1:0] mode, logic [5:0] nid,
			logic [5:0] din);
		logic [31:0] n;
		logic [31:0] r;
		int i;
		n = 32'(nid) & LOW_MASK;
		r = '0;
		case (mode)
			ncif_pkg::MODE_DIRECT:     r = 32'(din);
			ncif_pkg::MODE_TRANSPOSE:  r = ((n >> L_RS) | (n << L_LS)) & NODE_MASK;
			ncif_pkg::MODE_COMPLEMENT: r = ~32'(nid) & NODE_MASK;
			default: begin
				for (i = 0; i < ncif_pkg::NODE_L; i++) begin
					r[ncif_pkg::NODE_L-1-i] = n[i];
				end
			end
		endcase
		return r[5:0];
	endfunction

	state_t                          state_q;
	logic [5:0]                      node_id_q;
	logic [1:0]                      traffic_mode_q;
	logic [4:0]                      fpp_q;
	logic [4:0]                      queue_limit_q;
	logic [ncif_pkg::PTR_W-1:0]      wp_q;
	logic [ncif_pkg::PTR_W-1:0]      rp_q;
	logic [ncif_pkg::CNT_W-1:0]      count_q;
	logic [ncif_pkg::NUM_VCS-1:0]    cred_vld_q;
	logic [ncif_pkg::VC_W-1:0]       cr_idx_q;
	logic [ncif_pkg::VC_W-1:0]       best_q;
	logic [ncif_pkg::CRED_W-1:0]     best_cr_q;
	logic [4:0]                      fidx_q;
	logic [5:0]                      dest_q;
	logic [ncif_pkg::VC_W-1:0]       credit_vc_q;
	ncif_pkg::flit_t                 ent_q;
	logic                            r_sent_q;
	logic                            r_drop_q;
	logic                            out_valid_q;
	ncif_pkg::out_t                  out_q;

	ncif_pkg::flit_t                 flit_mem [ncif_pkg::QUEUE_DEPTH];
	ncif_pkg::flit_t                 flit_rd_q;
	logic                            flit_we;
	ncif_pkg::flit_t                 flit_wdata;

	logic [ncif_pkg::CRED_W-1:0]     cred_mem [ncif_pkg::NUM_VCS];
	logic [ncif_pkg::CRED_W-1:0]     cred_rd_q;
	logic                            cred_rdv_q;
	logic [ncif_pkg::VC_W-1:0]       cred_raddr;
	logic [ncif_pkg::VC_W-1:0]       cred_waddr;
	logic [ncif_pkg::CRED_W-1:0]     cred_wdata;
	logic                            cred_we;
	logic [ncif_pkg::CRED_W-1:0]     cred_val;

	logic                            in_acc;
	logic [ncif_pkg::SUM_W-1:0]      fit_sum;
	logic [ncif_pkg::SUM_W-1:0]      fit_limit;
	logic                            fits;
	logic                            vc_ok;
	logic                            last_flit;
	logic [ncif_pkg::PTR_W-1:0]      wp_next;
	logic [ncif_pkg::PTR_W-1:0]      rp_next;
	ncif_pkg::out_t                  res;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cred_val = cred_rdv_q ? cred_rd_q : ncif_pkg::CRED_W'(ncif_pkg::VC_BUFFER_DEPTH);

	assign fit_sum   = ncif_pkg::SUM_W'(count_q) + ncif_pkg::SUM_W'(fpp_q);
	assign fit_limit = (ncif_pkg::SUM_W'(queue_limit_q) > ncif_pkg::SUM_W'(ncif_pkg::QUEUE_DEPTH))
		? ncif_pkg::SUM_W'(ncif_pkg::QUEUE_DEPTH) : ncif_pkg::SUM_W'(queue_limit_q);
	assign fits      = (fit_sum <= fit_limit);
	assign vc_ok     = ({3'b000, in_data.credit_vc} < 5'(ncif_pkg::NUM_VCS));
	assign last_flit = (fidx_q == fpp_q - 5'd1);

	assign wp_next = (wp_q == ncif_pkg::PTR_W'(ncif_pkg::QUEUE_DEPTH - 1))
		? '0 : wp_q + 1'b1;
	assign rp_next = (rp_q == ncif_pkg::PTR_W'(ncif_pkg::QUEUE_DEPTH - 1))
		? '0 : rp_q + 1'b1;

	always_comb begin
		flit_we         = (state_q == ST_WRITE);
		flit_wdata.vc   = best_q;
		flit_wdata.head = (fidx_q == 5'd0);
		flit_wdata.tail = last_flit;
		flit_wdata.dest = (fidx_q == 5'd0) ? dest_q : 6'd0;

		// a generate starts its scan at VC 0
		case (state_q)
			ST_IDLE:    cred_raddr = (in_data.cmd == ncif_pkg::CMD_CREDIT)
				? ncif_pkg::VC_W'(in_data.credit_vc) : '0;
			ST_SCAN:    cred_raddr = cr_idx_q + 1'b1;
			ST_SEND_RD: cred_raddr = flit_rd_q.vc;
			default:    cred_raddr = '0;
		endcase

		cred_we    = 1'b0;
		cred_waddr = ent_q.vc;
		cred_wdata = cred_val - 1'b1;
		case (state_q)
			ST_SEND_CHK: cred_we = (cred_val != '0);
			ST_CRED: begin
				cred_we    = (cred_val < ncif_pkg::CRED_W'(ncif_pkg::VC_BUFFER_DEPTH));
				cred_waddr = credit_vc_q;
				cred_wdata = cred_val + 1'b1;
			end
			default: cred_we = 1'b0;
		endcase

		res.flit_sent      = r_sent_q;
		res.flit_vc        = r_sent_q ? 2'(ent_q.vc) : 2'd0;
		res.flit_head      = r_sent_q && ent_q.head;
		res.flit_tail      = r_sent_q && ent_q.tail;
		res.flit_dest      = r_sent_q ? ent_q.dest : 6'd0;
		res.packet_dropped = r_drop_q;
		res.queue_fill     = 5'(count_q);
	end

	always_ff @(posedge clk) begin
		if (flit_we) begin
			flit_mem[wp_q] <= flit_wdata;
		end
		flit_rd_q <= flit_mem[rp_q];
	end

	always_ff @(posedge clk) begin
		if (cred_we) begin
			cred_mem[cred_waddr] <= cred_wdata;
		end
		cred_rd_q <= cred_mem[cred_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			node_id_q      <= 6'd0;
			traffic_mode_q <= ncif_pkg::MODE_DIRECT;
			fpp_q          <= 5'd4;
			queue_limit_q  <= 5'd16;
			wp_q           <= '0;
			rp_q           <= '0;
			count_q        <= '0;
			cred_vld_q     <= '0;
			cred_rdv_q     <= 1'b0;
			cr_idx_q       <= '0;
			best_q         <= '0;
			best_cr_q      <= '0;
			fidx_q         <= '0;
			dest_q         <= '0;
			credit_vc_q    <= '0;
			ent_q          <= '0;
			r_sent_q       <= 1'b0;
			r_drop_q       <= 1'b0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			cred_rdv_q <= cred_vld_q[cred_raddr];
			if (cred_we) begin
				cred_vld_q[cred_waddr] <= 1'b1;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ncif_pkg::REG_NODE_ID:       node_id_q      <= cfg_data[5:0];
					ncif_pkg::REG_TRAFFIC_MODE:  traffic_mode_q <= cfg_data[1:0];
					ncif_pkg::REG_FLITS_PER_PKT: fpp_q          <= cfg_data[4:0];
					ncif_pkg::REG_QUEUE_LIMIT:   queue_limit_q  <= cfg_data[4:0];
					default: ;
				endcase
			end

			if (state_q == ST_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						r_sent_q    <= 1'b0;
						r_drop_q    <= 1'b0;
						cr_idx_q    <= '0;
						fidx_q      <= '0;
						credit_vc_q <= ncif_pkg::VC_W'(in_data.credit_vc);
						dest_q      <= pattern_dest(traffic_mode_q, node_id_q, in_data.dest_in);
						case (in_data.cmd)
							ncif_pkg::CMD_GEN: begin
								if (!fits) begin
									r_drop_q <= 1'b1;
									state_q  <= ST_FIN;
								end else if (fpp_q == 5'd0) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							ncif_pkg::CMD_SEND: begin
								if (count_q != '0 && in_data.channel_free) begin
									state_q <= ST_SEND_RD;
								end else begin
									state_q <= ST_FIN;
								end
							end
							ncif_pkg::CMD_CREDIT: state_q <= vc_ok ? ST_CRED : ST_FIN;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_SCAN: begin
					if (cr_idx_q == '0 || cred_val > best_cr_q) begin
						best_q    <= cr_idx_q;
						best_cr_q <= cred_val;
					end
					if (cr_idx_q == ncif_pkg::VC_W'(ncif_pkg::NUM_VCS - 1)) begin
						state_q <= ST_WRITE;
					end else begin
						cr_idx_q <= cr_idx_q + 1'b1;
					end
				end
				ST_WRITE: begin
					wp_q    <= wp_next;
					count_q <= count_q + 1'b1;
					fidx_q  <= fidx_q + 5'd1;
					if (last_flit) begin
						state_q <= ST_FIN;
					end
				end
				ST_SEND_RD: begin
					ent_q   <= flit_rd_q;
					state_q <= ST_SEND_CHK;
				end
				ST_SEND_CHK: begin
					if (cred_val != '0) begin
						r_sent_q <= 1'b1;
						rp_q     <= rp_next;
						count_q  <= count_q - 1'b1;
					end
					state_q <= ST_FIN;
				end
				ST_CRED: state_q <= ST_FIN;
				ST_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_q   <= res;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`NCIF_ASSERT_ALWAYS(a_count_bound, count_q <= ncif_pkg::CNT_W'(ncif_pkg::QUEUE_DEPTH), "flit count above queue depth")
	`NCIF_ASSERT_IMPL(a_write_room, state_q == ST_WRITE, count_q < ncif_pkg::CNT_W'(ncif_pkg::QUEUE_DEPTH), "flit write into a full queue")
	`NCIF_ASSERT_IMPL(a_send_nonempty, state_q == ST_SEND_RD || state_q == ST_SEND_CHK, count_q != '0, "send path entered with empty queue")
	`NCIF_ASSERT_IMPL(a_cred_bound, cred_we, cred_wdata <= ncif_pkg::CRED_W'(ncif_pkg::VC_BUFFER_DEPTH), "credit written above buffer depth")
	`NCIF_ASSERT_IMPL(a_sent_no_drop, out_valid_q && out_q.flit_sent, !out_q.packet_dropped, "result both sent and dropped")

endmodule
